>>> rtl/core/moving_average_peak_normalizer_assert.svh
// Assertion macros for the moving average peak normalizer.
// Included by the top level; no other dependencies.
`ifndef MOVING_AVERAGE_PEAK_NORMALIZER_ASSERT_SVH
`define MOVING_AVERAGE_PEAK_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MAPN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mapn assertion failed");

// Next-cycle implication, disabled during reset
`define MAPN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mapn assertion failed");

`endif

>>> rtl/core/mapn_pkg.sv
// Shared constants, types and register codes for the moving average peak normalizer.
// No dependencies.
package mapn_pkg;

    // Window and sample geometry
    localparam int WINDOW_LEN  = 30;
    localparam int SAMPLE_BITS = 12;
    localparam int SLOT_BITS   = $clog2(WINDOW_LEN);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN);

    // Division by the window length as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = SUM_BITS + SLOT_BITS + 1;
    localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(WINDOW_LEN) + 2;
    localparam longint RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
    localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(RECIP_VAL);
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    // Scaling and output widths
    localparam int GAIN_BITS   = 16;
    localparam int LEVEL_BITS  = 16;
    localparam int NUM_BITS    = SAMPLE_BITS + GAIN_BITS;
    localparam int DIV_CNT_BITS = $clog2(LEVEL_BITS + 1);

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFF_LEVEL = 1'd1;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET      = 16'd1000;
    localparam logic [LEVEL_BITS-1:0] OFF_LEVEL_RESET = 16'd15990;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [SAMPLE_BITS-1:0] peak;
    } entry_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0]  gain;
        logic [LEVEL_BITS-1:0] off_level;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } back_status_t;

endpackage

>>> rtl/core/mapn_if.sv
// Handshake channel interfaces for samples in and results out.
// Depends on mapn_pkg.
interface mapn_sample_if;
    logic                             valid;
    logic                             ready;
    logic [mapn_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mapn_result_if;
    logic                            valid;
    logic                            ready;
    logic [mapn_pkg::LEVEL_BITS-1:0] pulse_width;
    logic [mapn_pkg::LEVEL_BITS-1:0] level;

    modport source (output valid, output pulse_width, output level, input ready);
    modport sink   (input valid, input pulse_width, input level, output ready);
endinterface

>>> rtl/core/mapn_front.sv
// Front end: takes samples, keeps the ring, running sum and peak.
// Depends on mapn_pkg and mapn_if.
module mapn_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    mapn_sample_if.sink           in_ch,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mapn_pkg::entry_t      push_entry
);

    logic [mapn_pkg::SAMPLE_BITS-1:0] window_reg [mapn_pkg::WINDOW_LEN];
    logic [mapn_pkg::SLOT_BITS-1:0]   slot_reg;
    logic [mapn_pkg::SLOT_BITS-1:0]   slot_next;
    logic [mapn_pkg::SUM_BITS-1:0]    sum_reg;
    logic [mapn_pkg::SUM_BITS-1:0]    sum_next;
    logic [mapn_pkg::SAMPLE_BITS-1:0] peak_reg;
    logic [mapn_pkg::SAMPLE_BITS-1:0] peak_next;
    logic                             take;

    assign in_ch.ready = push_ready;
    assign take        = in_ch.valid & push_ready;

    // Window update: drop the oldest sample, add the new one
    always_comb
    begin
        sum_next  = sum_reg - mapn_pkg::SUM_BITS'(window_reg[slot_reg])
                  + mapn_pkg::SUM_BITS'(in_ch.sample);
        peak_next = (in_ch.sample > peak_reg) ? in_ch.sample : peak_reg;
        if (slot_reg == mapn_pkg::SLOT_BITS'(mapn_pkg::WINDOW_LEN - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    assign push_valid      = in_ch.valid;
    assign push_entry.sum  = sum_next;
    assign push_entry.peak = peak_next;

    // Ring and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mapn_pkg::WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
            peak_reg <= '0;
        end
        else if (take)
        begin
            window_reg[slot_reg] <= in_ch.sample;
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
        end
    end

endmodule

>>> rtl/core/mapn_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on mapn_pkg.
module mapn_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mapn_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mapn_pkg::entry_t pop_entry
);

    mapn_pkg::entry_t                ent_reg [mapn_pkg::QUEUE_DEPTH];
    logic [mapn_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [mapn_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [mapn_pkg::QCNT_BITS-1:0]  count_reg;
    logic                            push;
    logic                            pop;

    assign push_ready = (count_reg != mapn_pkg::QCNT_BITS'(mapn_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = ent_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/mapn_back.sv
// Back end: average, scale by gain, divide by peak bit-serially, form pulse width.
// Depends on mapn_pkg and mapn_if.
module mapn_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mapn_pkg::cfg_t          cfg,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  mapn_pkg::entry_t        pop_entry,
    mapn_result_if.source           out_ch,
    output mapn_pkg::back_status_t  status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AVG   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [mapn_pkg::SUM_BITS-1:0]       sum_reg;
    logic [mapn_pkg::SAMPLE_BITS-1:0]    peak_reg;
    logic [mapn_pkg::SAMPLE_BITS-1:0]    avg_reg;
    logic [mapn_pkg::SAMPLE_BITS-1:0]    rem_reg;
    logic [mapn_pkg::LEVEL_BITS-1:0]     quo_reg;
    logic [mapn_pkg::DIV_CNT_BITS-1:0]   cnt_reg;
    logic                                out_valid_reg;
    logic [mapn_pkg::LEVEL_BITS-1:0]     pulse_reg;
    logic [mapn_pkg::LEVEL_BITS-1:0]     level_reg;

    logic [mapn_pkg::PROD_BITS-1:0]      recip_prod;
    logic [mapn_pkg::NUM_BITS-1:0]       scale_prod;
    logic [mapn_pkg::SAMPLE_BITS:0]      trial;
    logic                                fits;
    logic [mapn_pkg::LEVEL_BITS-1:0]     level_val;
    logic [mapn_pkg::LEVEL_BITS-1:0]     pulse_val;
    logic                                load_out;

    assign pop_ready       = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.pulse_width = pulse_reg;
    assign out_ch.level    = level_reg;
    assign status.busy     = (state_reg != ST_IDLE);
    assign status.out_full = out_valid_reg;

    // Datapath arithmetic for each step
    always_comb
    begin
        recip_prod = mapn_pkg::PROD_BITS'(sum_reg) * mapn_pkg::PROD_BITS'(mapn_pkg::RECIP_MUL);
        scale_prod = mapn_pkg::NUM_BITS'(avg_reg) * mapn_pkg::NUM_BITS'(cfg.gain);
        trial      = {rem_reg, quo_reg[mapn_pkg::LEVEL_BITS-1]};
        fits       = (trial >= {1'b0, peak_reg});
        level_val  = (peak_reg == '0) ? '0 : quo_reg;
        pulse_val  = (level_val > cfg.off_level) ? '0 : (cfg.off_level - level_val);
        load_out   = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
    end

    // Step sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == mapn_pkg::DIV_CNT_BITS'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers: capture, average, scale, restoring division
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sum_reg  <= pop_entry.sum;
                peak_reg <= pop_entry.peak;
            end
            ST_AVG:
            begin
                avg_reg <= recip_prod[mapn_pkg::RECIP_SHIFT +: mapn_pkg::SAMPLE_BITS];
            end
            ST_SCALE:
            begin
                rem_reg <= scale_prod[mapn_pkg::NUM_BITS-1 -: mapn_pkg::SAMPLE_BITS];
                quo_reg <= scale_prod[mapn_pkg::LEVEL_BITS-1:0];
                cnt_reg <= mapn_pkg::DIV_CNT_BITS'(mapn_pkg::LEVEL_BITS);
            end
            ST_DIV:
            begin
                if (fits)
                begin
                    rem_reg <= mapn_pkg::SAMPLE_BITS'(trial - {1'b0, peak_reg});
                end
                else
                begin
                    rem_reg <= trial[mapn_pkg::SAMPLE_BITS-1:0];
                end
                quo_reg <= {quo_reg[mapn_pkg::LEVEL_BITS-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pulse_reg <= pulse_val;
            level_reg <= level_val;
        end
    end

endmodule

>>> rtl/core/moving_average_peak_normalizer.sv
// Moving average peak normalizer: window of recent samples, average scaled by
// gain over the running peak, subtracted from an off level to give a pulse width.
//
// Channels: in_ch carries one 12-bit sample per transfer (valid/ready); out_ch
// carries one result (pulse_width, level) per sample, in order.
// Config: cfg_wr_en with cfg_index 0 writes gain, index 1 writes off_level;
// other indexes are ignored. Write only while no sample is in flight.
// Path: the sample is written into the queue, then the back end captures it,
// averages it, scales it by gain, runs 16 divider steps and loads the output
// register. The bit-serial divider by the peak sets the rate, and the back end
// handles one item at a time.
// The two-entry queue lets the front take up to two samples ahead, and one
// finished result may wait in the output register while the next is computed.
// Reset clears the window, running sum, peak and write slot at once and
// restores gain 1000 and off level 15990; no clearing pass is needed.
// When the receiver stalls, the back end holds its result and the queue fills;
// in_ch.ready drops when the queue is full.
// Depends on mapn_pkg, mapn_if, mapn_front, mapn_queue, mapn_back and the assertion header.
`include "moving_average_peak_normalizer_assert.svh"

module moving_average_peak_normalizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mapn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mapn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mapn_sample_if.sink                         in_ch,
    mapn_result_if.source                       out_ch
);

    mapn_pkg::cfg_t         cfg_reg;
    logic                   push_valid;
    logic                   push_ready;
    mapn_pkg::entry_t       push_entry;
    logic                   pop_valid;
    logic                   pop_ready;
    mapn_pkg::entry_t       pop_entry;
    mapn_pkg::back_status_t back_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= mapn_pkg::GAIN_RESET;
            cfg_reg.off_level <= mapn_pkg::OFF_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mapn_pkg::CFG_GAIN:
                begin
                    cfg_reg.gain <= mapn_pkg::GAIN_BITS'(cfg_data);
                end
                mapn_pkg::CFG_OFF_LEVEL:
                begin
                    cfg_reg.off_level <= mapn_pkg::LEVEL_BITS'(cfg_data);
                end
                default:
                begin
                end
            endcase
        end
    end

    mapn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    mapn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mapn_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_ch    (out_ch),
        .status    (back_status)
    );

    // A zero peak means every sample so far was zero, so the sum is zero too
    `MAPN_ASSERT_NOW(a_zero_peak_zero_sum, clk, rst_n, push_valid && push_ready && (push_entry.peak == '0), push_entry.sum == '0)

    // The window sum never exceeds the window length times the peak
    `MAPN_ASSERT_NOW(a_sum_bounded, clk, rst_n, push_valid && push_ready, push_entry.sum <= mapn_pkg::SUM_BITS'(push_entry.peak) * mapn_pkg::SUM_BITS'(mapn_pkg::WINDOW_LEN))

    // Taking an entry from the queue starts the back end
    `MAPN_ASSERT_NEXT(a_pop_starts_back, clk, rst_n, pop_valid && pop_ready, back_status.busy)

    // A waiting result stays valid while the receiver stalls
    `MAPN_ASSERT_NEXT(a_out_held, clk, rst_n, back_status.out_full && !out_ch.ready, back_status.out_full)

endmodule

>>> dv/mapn_pulse_checker.sv
`timescale 1ns / 100ps
// Result checker for the moving average peak normalizer: watches the sample, result
// and register write ports, predicts each result and compares it field by field.
// Depends on mapn_pkg and the channel interfaces in mapn_if.
module mapn_pulse_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mapn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mapn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mapn_sample_if                              in_ch,
    mapn_result_if                              out_ch,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_checked
);
    import mapn_pkg::*;

    localparam int PRINT_CAP = 20;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] pulse_width;
        logic [LEVEL_BITS-1:0] level;
    } pulse_result_t;

    // Local copy of the window, running sum, peak and registers
    logic [SAMPLE_BITS-1:0] window_q [WINDOW_LEN];
    logic [SLOT_BITS-1:0]   slot_q;
    logic [SUM_BITS-1:0]    sum_q;
    logic [SAMPLE_BITS-1:0] peak_q;
    logic [GAIN_BITS-1:0]   gain_q;
    logic [LEVEL_BITS-1:0]  off_level_q;

    pulse_result_t pulse_expect_q [$];
    pulse_result_t want_r;
    int            errors_n;
    int            checked_n;

    // Takes one sample into the window and returns the pulse width and level it gives
    function automatic pulse_result_t advance_window(input logic [SAMPLE_BITS-1:0] s);
        pulse_result_t   r;
        longint unsigned avg;
        longint unsigned lvl;
        sum_q = sum_q - window_q[slot_q] + SUM_BITS'(s);
        window_q[slot_q] = s;
        if (s > peak_q)
            peak_q = s;
        slot_q = (slot_q == SLOT_BITS'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
        avg = 64'(sum_q) / 64'(WINDOW_LEN);
        // zero peak only while every sample so far was zero
        if (peak_q == '0)
            lvl = 0;
        else
            lvl = (avg * 64'(gain_q)) / 64'(peak_q);
        // average never exceeds the peak, so the level fits in 16 bits
        r.level = lvl[LEVEL_BITS-1:0];
        // saturate at zero when the level passes the off level
        r.pulse_width = (lvl > 64'(off_level_q)) ? '0 : off_level_q - r.level;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors_n < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        errors_n++;
    endtask

    // Predict on each sample transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (window_q[i])
                window_q[i] = '0;
            slot_q      = '0;
            sum_q       = '0;
            peak_q      = '0;
            gain_q      = GAIN_RESET;
            off_level_q = OFF_LEVEL_RESET;
            pulse_expect_q.delete();
            errors_n    = 0;
            checked_n   = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_GAIN)
                    gain_q = cfg_data;
                else if (cfg_index == CFG_OFF_LEVEL)
                    off_level_q = cfg_data;
            end

            if (out_ch.valid && out_ch.ready)
            begin
                if (pulse_expect_q.size() == 0)
                    report_mismatch($sformatf("result pulse_width=%0d level=%0d with no sample pending",
                                              out_ch.pulse_width, out_ch.level));
                else
                begin
                    want_r = pulse_expect_q.pop_front();
                    checked_n++;
                    if (out_ch.pulse_width !== want_r.pulse_width)
                        report_mismatch($sformatf("pulse_width %0d, expected %0d",
                                                  out_ch.pulse_width, want_r.pulse_width));
                    if (out_ch.level !== want_r.level)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  out_ch.level, want_r.level));
                end
            end

            if (in_ch.valid && in_ch.ready)
                pulse_expect_q.push_back(advance_window(in_ch.sample));

            mismatches      <= errors_n;
            outstanding     <= pulse_expect_q.size();
            results_checked <= checked_n;
        end
    end

endmodule

>>> dv/moving_average_peak_normalizer_tb.sv
`timescale 1ns / 100ps
// Top of the moving average peak normalizer testbench: clock, reset, sample and
// register stimulus, result-side stalls and the verdict.
// Depends on mapn_pkg, mapn_if, the block itself and mapn_pulse_checker.
module moving_average_peak_normalizer_tb;
    import mapn_pkg::*;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 325;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 170;
    localparam int SETTLE_CYCLES = 30;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      no_gaps;

    int mismatches;
    int outstanding;
    int results_checked;
    int samples_sent;
    int settings_used;
    int hold_left;
    bit hold_done;
    logic [SAMPLE_BITS-1:0] last_sample;

    mapn_sample_if in_ch ();
    mapn_result_if out_ch ();

    moving_average_peak_normalizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mapn_pulse_checker u_pulse_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls, one long hold-off while samples keep coming
    initial
    begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && results_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // One sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        samples_sent++;
        last_sample = s;
    endtask

    // Stop offering samples until every result has come back
    task automatic drain_results;
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Writes gain and then off level as back-to-back register writes
    task automatic apply_config(input logic [CFG_DATA_BITS-1:0] gain,
                                input logic [CFG_DATA_BITS-1:0] off_level);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_index <= CFG_OFF_LEVEL;
        cfg_data  <= off_level;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Sample and register stimulus
    initial
    begin
        logic [SAMPLE_BITS-1:0] pick;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_GAIN;
        cfg_data     <= '0;
        no_gaps      <= 1'b0;
        samples_sent  = 0;
        settings_used = 0;
        last_sample   = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Reset settings: zero peak first, then a small peak, then full scale
        repeat (4) send_sample('0);
        send_sample(12'd1);
        send_sample(12'd0);
        send_sample('1);
        send_sample('1);
        send_sample(12'd2048);
        send_sample(12'd0);
        drain_results();

        // Level far above an off level of zero: pulse width saturates
        apply_config('1, '0);
        send_sample('1);
        send_sample('1);
        send_sample(12'd1);
        drain_results();

        // Zero gain, full off level
        apply_config('0, '1);
        send_sample('1);
        send_sample('0);
        drain_results();

        // Both registers at full scale
        apply_config('1, '1);
        repeat (3) send_sample('1);
        drain_results();

        // Level crossing a small off level
        apply_config('1, 16'd100);
        send_sample(12'd100);
        send_sample('1);
        drain_results();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       apply_config(GAIN_RESET, OFF_LEVEL_RESET);
                1:       apply_config('1, 16'($urandom));
                2:       apply_config(16'($urandom), 16'($urandom));
                3:       apply_config('0, '1);
                4:       apply_config(16'($urandom_range(255, 1)), 16'($urandom_range(300)));
                default: apply_config('1, '1);
            endcase
            no_gaps <= (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: pick = SAMPLE_BITS'($urandom);
                    4, 5:       pick = SAMPLE_BITS'($urandom_range(63));
                    6, 7:       pick = SAMPLE_BITS'($urandom_range(4095, 4032));
                    default:    pick = last_sample;
                endcase
                send_sample(pick);
            end
            drain_results();
        end
        no_gaps <= 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d samples and %0d checked results: zero peak, saturation,",
                 samples_sent, results_checked);
        $display("extreme gains over %0d register settings, a %0d-cycle hold-off, a gap-free phase.",
                 settings_used, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("** moving_average_peak_normalizer: PASSED **");
        else
            $display("** moving_average_peak_normalizer: FAILED **");
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding", outstanding);
        $display("** moving_average_peak_normalizer: FAILED **");
        $finish;
    end

endmodule
